### rtl/assert_macros.svh
// Concurrent assertion macros used by the RTL top level; expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/iqbd_pkg.sv
// Shared types, constants and codes for the IQ burst detector and timing capture block.
package iqbd_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int WINDOW_LEN  = 3;

	localparam int THR_W   = 13;
	localparam int STEP_W  = 5;
	localparam int HALF_W  = 4;
	localparam int PAIRS_W = 4;
	localparam int LEN_W   = 12;
	localparam int CNT_W   = 12;
	localparam int GRP_W   = 2;
	localparam int ERR_W   = 4;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 13;

	// window sum and compare widths
	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);
	localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

	localparam logic [THR_W-1:0]   THR_RESET   = 13'd1400;
	localparam logic [STEP_W-1:0]  FULL_RESET  = 5'd8;
	localparam logic [HALF_W-1:0]  HALF_RESET  = 4'd4;
	localparam logic [PAIRS_W-1:0] PAIRS_RESET = 4'd9;
	localparam logic [LEN_W-1:0]   LEN_RESET   = 12'd768;

	localparam logic [1:0] CH_NONE = 2'd0;
	localparam logic [1:0] CH_I    = 2'd1;
	localparam logic [1:0] CH_Q    = 2'd2;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_REPLY = 2'd1,
		OP_ARM   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_SYNC    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_BURST   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_DETECT  = 3'd1,
		PH_TIMING  = 3'd2,
		PH_WAIT    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_THRESHOLD   = 3'd0,
		REG_FULL_STEP   = 3'd1,
		REG_HALF_STEP   = 3'd2,
		REG_PILOT_PAIRS = 3'd3,
		REG_PAYLOAD_LEN = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                    op;
		logic signed [SAMPLE_BITS-1:0] i_sample;
		logic signed [SAMPLE_BITS-1:0] q_sample;
		logic signed [ERR_W-1:0]       timing_error;
	} in_item_t;

	typedef struct packed {
		logic [1:0]                    kind;
		logic signed [SAMPLE_BITS-1:0] sync_i;
		logic signed [SAMPLE_BITS-1:0] sync_q;
		logic                          wants_error;
		logic signed [SAMPLE_BITS-1:0] payload_value;
		logic [CNT_W-1:0]              payload_index;
		logic                          last;
		logic [1:0]                    channel;
	} out_item_t;

	typedef struct packed {
		logic [THR_W-1:0]   power_threshold;
		logic [STEP_W-1:0]  full_step;
		logic [HALF_W-1:0]  half_step;
		logic [PAIRS_W-1:0] pilot_pairs;
		logic [LEN_W-1:0]   payload_length;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} win_ctrl_t;

	typedef struct packed {
		logic i_over;
		logic q_over;
	} win_det_t;

	typedef struct packed {
		phase_t            phase;
		logic [STEP_W-1:0] step;
	} seq_status_t;

endpackage

### rtl/iqbd_cfg.sv
// Configuration register file with reset defaults.
module iqbd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [iqbd_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [iqbd_pkg::CFG_DW-1:0]  cfg_wdata,
	output iqbd_pkg::cfg_t               cfg
);
	import iqbd_pkg::*;

	logic [THR_W-1:0]   thr_q;
	logic [STEP_W-1:0]  full_q;
	logic [HALF_W-1:0]  half_q;
	logic [PAIRS_W-1:0] pairs_q;
	logic [LEN_W-1:0]   len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			full_q  <= FULL_RESET;
			half_q  <= HALF_RESET;
			pairs_q <= PAIRS_RESET;
			len_q   <= LEN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_THRESHOLD:   thr_q   <= cfg_wdata[THR_W-1:0];
				REG_FULL_STEP:   full_q  <= cfg_wdata[STEP_W-1:0];
				REG_HALF_STEP:   half_q  <= cfg_wdata[HALF_W-1:0];
				REG_PILOT_PAIRS: pairs_q <= cfg_wdata[PAIRS_W-1:0];
				REG_PAYLOAD_LEN: len_q   <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.power_threshold = thr_q;
		cfg.full_step       = full_q;
		cfg.half_step       = half_q;
		cfg.pilot_pairs     = pairs_q;
		cfg.payload_length  = len_q;
	end

endmodule

### rtl/iqbd_window.sv
// Sliding sample window per channel with absolute-sum threshold compare.
module iqbd_window (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  iqbd_pkg::win_ctrl_t                  ctrl,
	input  logic signed [iqbd_pkg::SAMPLE_BITS-1:0] si,
	input  logic signed [iqbd_pkg::SAMPLE_BITS-1:0] sq,
	input  logic [iqbd_pkg::THR_W-1:0]           threshold,
	output iqbd_pkg::win_det_t                   det
);
	import iqbd_pkg::*;

	logic signed [SAMPLE_BITS-1:0] win_i_q [WINDOW_LEN];
	logic signed [SAMPLE_BITS-1:0] win_q_q [WINDOW_LEN];

	// window as it will be after the shift: oldest entry dropped, new sample last
	logic signed [SAMPLE_BITS-1:0] nxt_i [WINDOW_LEN];
	logic signed [SAMPLE_BITS-1:0] nxt_q [WINDOW_LEN];
	logic [SUM_W-1:0] sum_i;
	logic [SUM_W-1:0] sum_q;

	always_comb begin
		for (int k = 0; k < WINDOW_LEN - 1; k++) begin
			nxt_i[k] = win_i_q[k+1];
			nxt_q[k] = win_q_q[k+1];
		end
		nxt_i[WINDOW_LEN-1] = si;
		nxt_q[WINDOW_LEN-1] = sq;
	end

	always_comb begin
		sum_i = '0;
		sum_q = '0;
		for (int k = 0; k < WINDOW_LEN; k++) begin
			// magnitude fits in SAMPLE_BITS unsigned, including the most negative code
			sum_i = sum_i + SUM_W'(nxt_i[k][SAMPLE_BITS-1] ?
				SAMPLE_BITS'(~nxt_i[k] + 1'b1) : SAMPLE_BITS'(nxt_i[k]));
			sum_q = sum_q + SUM_W'(nxt_q[k][SAMPLE_BITS-1] ?
				SAMPLE_BITS'(~nxt_q[k] + 1'b1) : SAMPLE_BITS'(nxt_q[k]));
		end
		det.i_over = CMP_W'(sum_i) > CMP_W'(threshold);
		det.q_over = CMP_W'(sum_q) > CMP_W'(threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW_LEN; k++) begin
				win_i_q[k] <= '0;
				win_q_q[k] <= '0;
			end
		end else if (ctrl.clear) begin
			for (int k = 0; k < WINDOW_LEN; k++) begin
				win_i_q[k] <= '0;
				win_q_q[k] <= '0;
			end
		end else if (ctrl.shift) begin
			for (int k = 0; k < WINDOW_LEN; k++) begin
				win_i_q[k] <= nxt_i[k];
				win_q_q[k] <= nxt_q[k];
			end
		end
	end

endmodule

### rtl/iqbd_seq.sv
// Phase sequencer: strobe timing, counters and result formation for each transaction.
module iqbd_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  iqbd_pkg::in_item_t    item,
	input  iqbd_pkg::cfg_t        cfg,
	input  iqbd_pkg::win_det_t    det,
	output iqbd_pkg::win_ctrl_t   wctl,
	output logic                  res_fire,
	output iqbd_pkg::out_item_t   res_item,
	output iqbd_pkg::seq_status_t status
);
	import iqbd_pkg::*;

	phase_t            phase_q, phase_n;
	logic [STEP_W-1:0] tick_q, tick_n;
	logic [STEP_W-1:0] step_q, step_n;
	logic [CNT_W-1:0]  gc_q, gc_n;
	logic [GRP_W-1:0]  grp_q, grp_n;
	logic [1:0]        chan_q, chan_n;

	logic [STEP_W-1:0] tick_inc;
	logic              hit;
	logic [CNT_W-1:0]  gc_inc;
	logic [CNT_W:0]    gc_inc_wide;
	logic [GRP_W-1:0]  grp_inc;
	logic [CNT_W-1:0]  fill;
	logic signed [STEP_W+1:0] corr;

	// strobe distance saturates to 1..31
	function automatic logic [STEP_W-1:0] clamp_step(input logic signed [STEP_W+1:0] s);
		logic [STEP_W-1:0] r;
		if (s < 1)
			r = STEP_W'(1);
		else if (s > $signed((STEP_W+2)'({STEP_W{1'b1}})))
			r = {STEP_W{1'b1}};
		else
			r = s[STEP_W-1:0];
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			step_q  <= STEP_W'(1);
			gc_q    <= '0;
			grp_q   <= '0;
			chan_q  <= CH_NONE;
		end else begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			step_q  <= step_n;
			gc_q    <= gc_n;
			grp_q   <= grp_n;
			chan_q  <= chan_n;
		end
	end

	always_comb begin
		tick_inc    = tick_q + 1'b1;
		hit         = tick_inc == step_q;
		gc_inc      = gc_q + 1'b1;
		gc_inc_wide = {1'b0, gc_q} + 1'b1;
		grp_inc     = grp_q + 1'b1;
		fill        = (gc_q < CNT_W'(WINDOW_LEN)) ? gc_inc : gc_q;
		corr        = $signed({2'b00, cfg.full_step}) -
			$signed({{2{item.timing_error[ERR_W-1]}}, item.timing_error});

		phase_n  = phase_q;
		tick_n   = tick_q;
		step_n   = step_q;
		gc_n     = gc_q;
		grp_n    = grp_q;
		chan_n   = chan_q;
		wctl     = '0;
		res_fire = 1'b0;
		res_item = '0;

		if (accept) begin
			case (item.op)
				OP_ARM: begin
					phase_n    = PH_DETECT;
					tick_n     = '0;
					step_n     = STEP_W'(1);
					gc_n       = '0;
					grp_n      = '0;
					chan_n     = CH_NONE;
					wctl.clear = 1'b1;
				end
				OP_REPLY: begin
					if (phase_q == PH_WAIT) begin
						step_n = clamp_step(corr);
						tick_n = '0;
						if (gc_inc >= CNT_W'(cfg.pilot_pairs)) begin
							gc_n    = '0;
							phase_n = PH_PAYLOAD;
						end else begin
							gc_n    = gc_inc;
							phase_n = PH_TIMING;
						end
					end
				end
				OP_TICK: begin
					case (phase_q)
						PH_DETECT: begin
							tick_n = hit ? '0 : tick_inc;
							if (hit) begin
								step_n     = STEP_W'(1);
								wctl.shift = 1'b1;
								gc_n       = fill;
								// trigger only once the window is full; I wins over Q
								if (fill >= CNT_W'(WINDOW_LEN) && (det.i_over || det.q_over)) begin
									chan_n           = det.i_over ? CH_I : CH_Q;
									gc_n             = '0;
									grp_n            = '0;
									tick_n           = '0;
									phase_n          = PH_TIMING;
									res_fire         = 1'b1;
									res_item.kind    = KIND_BURST;
									res_item.channel = det.i_over ? CH_I : CH_Q;
								end
							end
						end
						PH_TIMING: begin
							tick_n = hit ? '0 : tick_inc;
							if (hit) begin
								step_n           = clamp_step($signed({3'b000, cfg.half_step}));
								res_fire         = 1'b1;
								res_item.kind    = KIND_SYNC;
								res_item.sync_i  = item.i_sample;
								res_item.sync_q  = item.q_sample;
								res_item.channel = chan_q;
								if (grp_inc == GRP_W'(3)) begin
									grp_n                = '0;
									res_item.wants_error = 1'b1;
									phase_n              = PH_WAIT;
								end else begin
									grp_n = grp_inc;
								end
							end
						end
						PH_PAYLOAD: begin
							tick_n = hit ? '0 : tick_inc;
							if (hit) begin
								step_n                 = clamp_step($signed({2'b00, cfg.full_step}));
								res_fire               = 1'b1;
								res_item.kind          = KIND_PAYLOAD;
								res_item.payload_value = (chan_q == CH_Q) ?
									item.q_sample : item.i_sample;
								res_item.payload_index = gc_q;
								res_item.channel       = chan_q;
								if (gc_inc_wide >= {1'b0, cfg.payload_length}) begin
									res_item.last = 1'b1;
									phase_n       = PH_DONE;
									tick_n        = '0;
									step_n        = STEP_W'(1);
									gc_n          = '0;
									grp_n         = '0;
								end else begin
									gc_n = gc_inc;
								end
							end
						end
						default: ; // idle, wait and done drop ticks
					endcase
				end
				default: ;
			endcase
		end

		status.phase = phase_q;
		status.step  = step_q;
	end

endmodule

### rtl/iqbd_oreg.sv
// Result output register with valid/ready handshake.
module iqbd_oreg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  iqbd_pkg::out_item_t din,
	input  logic                ready,
	output logic                valid,
	output iqbd_pkg::out_item_t dout,
	output logic                free
);
	import iqbd_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	// register is free when empty or being drained this cycle
	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign dout  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= din;
	end

endmodule

### rtl/iq_burst_detect_timing_capture.sv
// Top level: IQ burst detector, timing sync sequencer and payload capture.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_ready     in_item_t
//   result    out        result_valid / result_ready out_item_t
//   cfg       in         cfg_wr_en                   cfg_addr, cfg_wdata
//
// One transaction per cycle while item_ready is high; a result appears in the cycle after
// the transaction that causes it, held in a single output register.
// item_ready is high while the output register is empty or being drained.
// Reset returns the sequencer to idle and the registers to their defaults.
// Ticks in idle, done or while waiting for a timing reply are taken and dropped.
`include "assert_macros.svh"

module iq_burst_detect_timing_capture (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  iqbd_pkg::in_item_t           item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output iqbd_pkg::out_item_t          result,
	input  logic                         cfg_wr_en,
	input  logic [iqbd_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [iqbd_pkg::CFG_DW-1:0]  cfg_wdata
);
	import iqbd_pkg::*;

	cfg_t        cfg;
	win_ctrl_t   wctl;
	win_det_t    det;
	logic        accept;
	logic        res_fire;
	out_item_t   res_item;
	seq_status_t status;

	assign accept = item_valid && item_ready;

	iqbd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	iqbd_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (wctl),
		.si        (item.i_sample),
		.sq        (item.q_sample),
		.threshold (cfg.power_threshold),
		.det       (det)
	);

	iqbd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg),
		.det      (det),
		.wctl     (wctl),
		.res_fire (res_fire),
		.res_item (res_item),
		.status   (status)
	);

	iqbd_oreg u_oreg (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (res_fire),
		.din   (res_item),
		.ready (result_ready),
		.valid (result_valid),
		.dout  (result),
		.free  (item_ready)
	);

	`ASSERT_ALWAYS(a_step_nonzero, status.step != '0, "strobe distance is zero")
	`ASSERT_NEXT(a_wait_holds, accept && item.op == OP_TICK && status.phase == PH_WAIT, status.phase == PH_WAIT, "tick left the reply wait")
	`ASSERT_NEXT(a_last_done, res_fire && res_item.last, status.phase == PH_DONE, "last payload sample did not end the burst")
	`ASSERT_IMPLY(a_burst_channel, result_valid && result.kind == KIND_BURST, result.channel == CH_I || result.channel == CH_Q, "burst result without a channel")

endmodule

### test/testbench.sv
// Self-checking testbench for the IQ burst detector with timing sync and payload capture.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import iqbd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_IDLE    = 15;
	localparam int SETTLE      = 4;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	in_item_t            item         = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	out_item_t           result;
	logic                cfg_wr_en    = 1'b0;
	logic [CFG_AW-1:0]   cfg_addr     = '0;
	logic [CFG_DW-1:0]   cfg_wdata    = '0;

	iq_burst_detect_timing_capture dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mirror of the sequencer state and registers
	cfg_t              cfg_mirror;
	phase_t            seq_phase;
	logic [STEP_W-1:0] tick_cnt;
	logic [STEP_W-1:0] strobe_dist;
	int                win_i [WINDOW_LEN];
	int                win_q [WINDOW_LEN];
	logic [CNT_W-1:0]  gen_cnt;
	logic [GRP_W-1:0]  group_cnt;
	logic [1:0]        trig_ch;

	out_item_t pending_results[$];
	int        cycle_count = 0;
	int        errors      = 0;
	int        live_count  = 0;
	int        gap_max     = MAX_IDLE;
	int        stall_max   = MAX_IDLE;

	typedef struct {
		in_item_t  stim;
		int        reps;
		bit        typed;
		bit        hit;
		out_item_t want;
	} stim_row_t;

	stim_row_t stim_rows[$];

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic void clear_run();
		tick_cnt    = '0;
		strobe_dist = STEP_W'(1);
		gen_cnt     = '0;
		group_cnt   = '0;
		trig_ch     = CH_NONE;
		for (int k = 0; k < WINDOW_LEN; k++) begin
			win_i[k] = 0;
			win_q[k] = 0;
		end
	endfunction

	function automatic logic [STEP_W-1:0] sat_step(int s);
		if (s < 1)
			return STEP_W'(1);
		if (s > 31)
			return STEP_W'(31);
		return s[STEP_W-1:0];
	endfunction

	function automatic int mag_sum(input int w [WINDOW_LEN]);
		int s;
		s = 0;
		for (int k = 0; k < WINDOW_LEN; k++)
			s += (w[k] < 0) ? -w[k] : w[k];
		return s;
	endfunction

	function automatic bit strobe_hit();
		tick_cnt = tick_cnt + 1'b1;
		if (tick_cnt != strobe_dist)
			return 1'b0;
		tick_cnt = '0;
		return 1'b1;
	endfunction

	// advance the mirror by one accepted item; live is low for items the block drops
	task automatic sequencer_step(input in_item_t it, output bit hit, output out_item_t r,
			output bit live);
		int e;
		hit  = 1'b0;
		live = 1'b1;
		r    = '0;
		case (it.op)
			OP_ARM: begin
				clear_run();
				seq_phase = PH_DETECT;
			end
			OP_REPLY: begin
				if (seq_phase != PH_WAIT) begin
					live = 1'b0;
				end else begin
					e           = int'($signed(it.timing_error));
					strobe_dist = sat_step(int'(cfg_mirror.full_step) - e);
					tick_cnt    = '0;
					gen_cnt     = gen_cnt + 1'b1;
					if (gen_cnt >= CNT_W'(cfg_mirror.pilot_pairs)) begin
						gen_cnt   = '0;
						seq_phase = PH_PAYLOAD;
					end else begin
						seq_phase = PH_TIMING;
					end
				end
			end
			OP_TICK: begin
				case (seq_phase)
					PH_DETECT: begin
						if (strobe_hit()) begin
							strobe_dist = STEP_W'(1);
							for (int k = 0; k + 1 < WINDOW_LEN; k++) begin
								win_i[k] = win_i[k + 1];
								win_q[k] = win_q[k + 1];
							end
							win_i[WINDOW_LEN - 1] = int'($signed(it.i_sample));
							win_q[WINDOW_LEN - 1] = int'($signed(it.q_sample));
							if (gen_cnt < WINDOW_LEN)
								gen_cnt = gen_cnt + 1'b1;
							if (gen_cnt == WINDOW_LEN) begin
								if (mag_sum(win_i) > int'(cfg_mirror.power_threshold))
									trig_ch = CH_I;
								else if (mag_sum(win_q) > int'(cfg_mirror.power_threshold))
									trig_ch = CH_Q;
								if (trig_ch != CH_NONE) begin
									gen_cnt     = '0;
									group_cnt   = '0;
									strobe_dist = STEP_W'(1);
									tick_cnt    = '0;
									seq_phase   = PH_TIMING;
									hit         = 1'b1;
									r.kind      = KIND_BURST;
									r.channel   = trig_ch;
								end
							end
						end
					end
					PH_TIMING: begin
						if (strobe_hit()) begin
							strobe_dist = sat_step(int'(cfg_mirror.half_step));
							hit         = 1'b1;
							r.kind      = KIND_SYNC;
							r.sync_i    = it.i_sample;
							r.sync_q    = it.q_sample;
							r.channel   = trig_ch;
							group_cnt   = group_cnt + 1'b1;
							if (group_cnt == 3) begin
								group_cnt     = '0;
								r.wants_error = 1'b1;
								seq_phase     = PH_WAIT;
							end
						end
					end
					PH_PAYLOAD: begin
						if (strobe_hit()) begin
							strobe_dist     = sat_step(int'(cfg_mirror.full_step));
							hit             = 1'b1;
							r.kind          = KIND_PAYLOAD;
							r.payload_value = (trig_ch == CH_Q) ? it.q_sample : it.i_sample;
							r.payload_index = gen_cnt;
							r.channel       = trig_ch;
							if (int'(gen_cnt) + 1 >= int'(cfg_mirror.payload_length)) begin
								r.last      = 1'b1;
								seq_phase   = PH_DONE;
								tick_cnt    = '0;
								strobe_dist = STEP_W'(1);
								gen_cnt     = '0;
								group_cnt   = '0;
							end else begin
								gen_cnt = gen_cnt + 1'b1;
							end
						end
					end
					default: live = 1'b0;
				endcase
			end
			default: live = 1'b0;
		endcase
	endtask

	// mostly well-formed traffic steered by the mirrored phase, with some noise
	function automatic in_item_t pick_item();
		in_item_t it;
		int roll;
		int q;
		it.op           = OP_TICK;
		it.i_sample     = SAMPLE_BITS'($urandom);
		it.q_sample     = SAMPLE_BITS'($urandom);
		it.timing_error = ERR_W'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			it.op = 2'($urandom_range(0, 3));
			return it;
		end
		if (roll < 7) begin
			it.op = OP_ARM;
			return it;
		end
		case (seq_phase)
			PH_IDLE, PH_DONE: begin
				if (roll < 80)
					it.op = OP_ARM;
			end
			PH_DETECT: begin
				// quiet samples stay below the threshold over a full window
				if ($urandom_range(0, 2) != 0) begin
					q = int'(cfg_mirror.power_threshold) / 4;
					if (q > 2047)
						q = 2047;
					it.i_sample = SAMPLE_BITS'(int'($urandom_range(0, 2 * q)) - q);
					it.q_sample = SAMPLE_BITS'(int'($urandom_range(0, 2 * q)) - q);
				end
			end
			PH_WAIT: begin
				if (roll < 85)
					it.op = OP_REPLY;
			end
			default: ;
		endcase
		return it;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic offer_item(input in_item_t it, input bit typed, input bit hit,
			input out_item_t want);
		int        gap;
		bit        got_hit;
		bit        live;
		out_item_t r;
		if ($urandom_range(0, 63) == 0)
			gap_max = (gap_max != 0) ? 0 : MAX_IDLE;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sequencer_step(it, got_hit, r, live);
		if (typed) begin
			got_hit = hit;
			r       = want;
		end
		if (got_hit)
			pending_results.push_back(r);
		if (live)
			live_count++;
	endtask

	task automatic wait_drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD:   cfg_mirror.power_threshold = val[THR_W-1:0];
			REG_FULL_STEP:   cfg_mirror.full_step       = val[STEP_W-1:0];
			REG_HALF_STEP:   cfg_mirror.half_step       = val[HALF_W-1:0];
			REG_PILOT_PAIRS: cfg_mirror.pilot_pairs     = val[PAIRS_W-1:0];
			REG_PAYLOAD_LEN: cfg_mirror.payload_length  = val[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic run_setting(input cfg_t c, input int budget);
		wait_drain();
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_THRESHOLD, c.power_threshold);
		write_reg(REG_FULL_STEP, c.full_step);
		write_reg(REG_HALF_STEP, c.half_step);
		write_reg(REG_PILOT_PAIRS, c.pilot_pairs);
		write_reg(REG_PAYLOAD_LEN, c.payload_length);
		cfg_wr_en  <= 1'b0;
		live_count = 0;
		while (live_count < budget) begin
			offer_item(pick_item(), 1'b0, 1'b0, '0);
			if ($urandom_range(0, 199) == 0)
				wait_drain();
		end
	endtask

	task automatic table_row(input logic [1:0] op, input int si, input int sq, input int te,
			input int reps, input bit typed, input bit hit, input out_item_t want);
		stim_row_t row;
		row.stim.op           = op;
		row.stim.i_sample     = SAMPLE_BITS'(si);
		row.stim.q_sample     = SAMPLE_BITS'(sq);
		row.stim.timing_error = ERR_W'(te);
		row.reps  = reps;
		row.typed = typed;
		row.hit   = hit;
		row.want  = want;
		stim_rows.push_back(row);
	endtask

	// result side: random stalls, each transaction checked against the oldest expectation
	initial begin
		int        stall;
		out_item_t want;
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, stall_max);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d channel %0d",
					$time, result.kind, result.channel);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, result.kind);
				check_field("sync_i", $signed(want.sync_i), $signed(result.sync_i));
				check_field("sync_q", $signed(want.sync_q), $signed(result.sync_q));
				check_field("wants_error", want.wants_error, result.wants_error);
				check_field("payload_value", $signed(want.payload_value),
					$signed(result.payload_value));
				check_field("payload_index", want.payload_index, result.payload_index);
				check_field("last", want.last, result.last);
				check_field("channel", want.channel, result.channel);
			end
			if ($urandom_range(0, 39) == 0)
				stall_max = (stall_max != 0) ? 0 : MAX_IDLE;
		end
	end

	initial begin
		out_item_t none_r;
		out_item_t burst_i;
		out_item_t burst_q;
		out_item_t sync_i_ch;
		out_item_t sync_q_ch;
		cfg_t      c;

		cfg_mirror = '{power_threshold: THR_RESET, full_step: FULL_RESET,
			half_step: HALF_RESET, pilot_pairs: PAIRS_RESET, payload_length: LEN_RESET};
		seq_phase = PH_IDLE;
		clear_run();

		none_r    = '0;
		burst_i   = '{kind: KIND_BURST, channel: CH_I, default: '0};
		burst_q   = '{kind: KIND_BURST, channel: CH_Q, default: '0};
		sync_i_ch = '{kind: KIND_SYNC, sync_i: 12'sh7ff, sync_q: 12'sh800, channel: CH_I,
			default: '0};
		sync_q_ch = '{kind: KIND_SYNC, sync_i: 12'sd1, sync_q: 12'sd2, channel: CH_Q,
			default: '0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, register defaults
		table_row(OP_TICK,    100,  -100,  0, 1, 1, 0, none_r);  // idle: dropped
		table_row(OP_REPLY,     0,     0,  7, 1, 1, 0, none_r);  // not waiting
		table_row(OP_UNUSED, -2048, 2047, -8, 1, 1, 0, none_r);
		table_row(OP_ARM,       0,     0,  0, 1, 1, 0, none_r);
		table_row(OP_TICK,  -2048,  2047,  0, 1, 1, 0, none_r);  // window filling
		table_row(OP_TICK,   2047, -2048,  0, 1, 1, 0, none_r);
		table_row(OP_TICK,      0,     0,  0, 1, 1, 1, burst_i);
		table_row(OP_TICK,   2047, -2048,  0, 1, 1, 1, sync_i_ch);
		table_row(OP_REPLY,     0,     0, -8, 1, 1, 0, none_r);
		table_row(OP_TICK,      5,    -5,  0, 8, 0, 0, none_r);
		table_row(OP_TICK,      9,     9,  0, 2, 1, 0, none_r);  // waiting for reply
		table_row(OP_REPLY,     0,     0, -8, 1, 0, 0, none_r);
		table_row(OP_TICK,     -1,     1,  0, 16, 0, 0, none_r);
		table_row(OP_ARM,       0,     0,  0, 1, 1, 0, none_r);  // restart mid timing
		table_row(OP_TICK,    467,     0,  0, 2, 1, 0, none_r);
		table_row(OP_TICK,    466,     0,  0, 1, 1, 0, none_r);  // sum equals threshold
		table_row(OP_TICK,    468,     0,  0, 1, 1, 1, burst_i);
		table_row(OP_ARM,       0,     0,  0, 1, 1, 0, none_r);
		table_row(OP_TICK,      0, -2048,  0, 2, 1, 0, none_r);
		table_row(OP_TICK,      0, -2048,  0, 1, 1, 1, burst_q);
		table_row(OP_TICK,      1,     2,  0, 1, 1, 1, sync_q_ch);
		table_row(OP_TICK,    -77,    33,  0, 8, 0, 0, none_r);
		table_row(OP_REPLY,     0,     0,  7, 1, 0, 0, none_r);
		table_row(OP_ARM,       0,     0,  0, 1, 1, 0, none_r);

		foreach (stim_rows[r])
			repeat (stim_rows[r].reps)
				offer_item(stim_rows[r].stim, stim_rows[r].typed, stim_rows[r].hit,
					stim_rows[r].want);

		// all-zero registers: step saturation, zero pairs, zero payload length
		run_setting('{power_threshold: 0, full_step: 0, half_step: 0, pilot_pairs: 0,
			payload_length: 0}, 150);
		// all-ones registers: threshold out of reach
		run_setting('{power_threshold: 13'h1fff, full_step: 5'h1f, half_step: 4'hf,
			pilot_pairs: 4'hf, payload_length: 12'hfff}, 40);
		run_setting('{power_threshold: 200, full_step: 31, half_step: 15, pilot_pairs: 2,
			payload_length: 3}, 150);
		// longest payload, cut short by re-arming
		run_setting('{power_threshold: 1000, full_step: 8, half_step: 1, pilot_pairs: 1,
			payload_length: 4095}, 100);
		repeat (6) begin
			c.power_threshold = THR_W'($urandom_range(0, 4000));
			c.full_step       = STEP_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
				: $urandom_range(8, 16));
			c.half_step       = HALF_W'($urandom_range(0, 15));
			c.pilot_pairs     = PAIRS_W'($urandom_range(0, 4));
			c.payload_length  = LEN_W'($urandom_range(0, 8));
			run_setting(c, 135);
		end

		wait_drain();
		repeat (SETTLE * 2) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
